// ===== sv/ftli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftli_pkg
// Shared types, codes and the default low-pass coefficient table.
// ----------------------------------------------------------------------------
package ftli_pkg;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  localparam int SAMPLE_W = 13;
  localparam int COEF_W   = 16;
  localparam int TAPNUM_W = 8;
  localparam int VALUE_W  = 32;
  localparam int LEVEL_W  = 5;
  localparam int LED_W    = 8;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int FRAC_W   = 15;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  localparam logic signed [VALUE_W-1:0] LEVEL_OFFSET = -32'sd32;

  typedef struct packed {
    logic wr_sample;
    logic wr_coef;
    logic start;
    logic issue;
    logic filt;
    logic load_out;
  } ftli_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } ftli_stat_t;

  function automatic logic signed [COEF_W-1:0] ftli_default_coef(input logic [TAPNUM_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      8'd0:  c = 16'sd152;
      8'd1:  c = 16'sd242;
      8'd2:  c = -16'sd79;
      8'd3:  c = -16'sd233;
      8'd4:  c = 16'sd107;
      8'd5:  c = 16'sd2;
      8'd6:  c = -16'sd307;
      8'd7:  c = 16'sd130;
      8'd8:  c = 16'sd143;
      8'd9:  c = -16'sd436;
      8'd10: c = 16'sd100;
      8'd11: c = 16'sd375;
      8'd12: c = -16'sd587;
      8'd13: c = -16'sd35;
      8'd14: c = 16'sd729;
      8'd15: c = -16'sd737;
      8'd16: c = -16'sd356;
      8'd17: c = 16'sd1298;
      8'd18: c = -16'sd863;
      8'd19: c = -16'sd1106;
      8'd20: c = 16'sd2464;
      8'd21: c = -16'sd947;
      8'd22: c = -16'sd3944;
      8'd23: c = 16'sd9435;
      8'd24: c = 16'sd20869;
      8'd25: c = 16'sd9435;
      8'd26: c = -16'sd3944;
      8'd27: c = -16'sd947;
      8'd28: c = 16'sd2464;
      8'd29: c = -16'sd1106;
      8'd30: c = -16'sd863;
      8'd31: c = 16'sd1298;
      8'd32: c = -16'sd356;
      8'd33: c = -16'sd737;
      8'd34: c = 16'sd729;
      8'd35: c = -16'sd35;
      8'd36: c = -16'sd587;
      8'd37: c = 16'sd375;
      8'd38: c = 16'sd100;
      8'd39: c = -16'sd436;
      8'd40: c = 16'sd143;
      8'd41: c = 16'sd130;
      8'd42: c = -16'sd307;
      8'd43: c = 16'sd2;
      8'd44: c = 16'sd107;
      8'd45: c = -16'sd233;
      8'd46: c = -16'sd79;
      8'd47: c = 16'sd242;
      8'd48: c = 16'sd152;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/ftli_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftli_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ftli_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 49,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ftli_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftli_ctrl
// Request sequencer: accepts requests, steps the tap walk, hands off results.
// ----------------------------------------------------------------------------
module ftli_ctrl
  import ftli_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       req_valid,
  input  logic       req_cmd,
  output logic       req_ready,
  input  ftli_stat_t stat,
  output ftli_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MAC    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       filter_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      filter_enable <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        filter_enable <= cfg_wr_data;
      end
    end
  end

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.filt   = filter_enable;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req_cmd == CMD_COEF) begin
            cmd.wr_coef = 1'b1;
          end else begin
            cmd.wr_sample = 1'b1;
            cmd.start     = 1'b1;
            state_next    = filter_enable ? ST_MAC : ST_FINISH;
          end
        end
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (stat.last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ftli_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftli_dp
// Sample ring, coefficient store, shared multiply-accumulate and LED output.
// ----------------------------------------------------------------------------
module ftli_dp
  import ftli_pkg::*;
#(
  parameter int TAP_COUNT = 49,
  parameter int PWM_TOP   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ftli_cmd_t                  cmd,
  output ftli_stat_t                 stat,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [TAPNUM_W-1:0]        tap_number,
  input  logic signed [COEF_W-1:0]   tap_weight,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [LED_W-1:0]           led_pattern,
  output logic signed [VALUE_W-1:0]  signal_value,
  output logic [LEVEL_W-1:0]         tilt_level
);

  localparam int AW    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int CW    = $clog2(TAP_COUNT + 1);
  localparam int PW    = $clog2(PWM_TOP + 2);
  localparam int ACC_W = PROD_W + CW;

  logic [AW-1:0]              write_slot;
  logic [CW-1:0]              fill;
  logic signed [SAMPLE_W-1:0] sample_reg;
  logic [TAP_COUNT-1:0]       coef_vld;
  logic                       coef_in_range;
  logic [AW-1:0]              tap_k;
  logic [AW-1:0]              rd_idx;
  logic                       v1;
  logic                       v2;
  logic                       s_ok;
  logic                       c_ok;
  logic [AW-1:0]              tap_k_d;
  logic [SAMPLE_W-1:0]        ring_rdata;
  logic [COEF_W-1:0]          coef_rdata;
  logic signed [SAMPLE_W-1:0] samp_op;
  logic signed [COEF_W-1:0]   coef_op;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_adj;
  logic signed [VALUE_W-1:0]  fir_value;
  logic signed [VALUE_W-1:0]  value;
  logic [VALUE_W-1:0]         shifted;
  logic [2:0]                 sel;
  logic [LEVEL_W-1:0]         level;
  logic [LED_W-1:0]           led;
  logic [PW-1:0]              pwm_phase;

  assign coef_in_range = ({1'b0, tap_number} < 9'(TAP_COUNT));

  ftli_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAP_COUNT)) u_ring (
    .clk   (clk),
    .we    (cmd.wr_sample),
    .waddr (write_slot),
    .wdata (sample),
    .raddr (rd_idx),
    .rdata (ring_rdata)
  );

  ftli_ram #(.WIDTH(COEF_W), .DEPTH(TAP_COUNT)) u_coef (
    .clk   (clk),
    .we    (cmd.wr_coef && coef_in_range),
    .waddr (tap_number[AW-1:0]),
    .wdata (tap_weight),
    .raddr (tap_k),
    .rdata (coef_rdata)
  );

  // ring slots never written read as zero, coefficients never written read as default
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill       <= '0;
      coef_vld   <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      pwm_phase  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.wr_sample) begin
        write_slot <= (write_slot == AW'(TAP_COUNT - 1)) ? '0 : write_slot + AW'(1);
        if (fill != CW'(TAP_COUNT)) begin
          fill <= fill + CW'(1);
        end
      end
      if (cmd.wr_coef && coef_in_range) begin
        coef_vld[tap_number[AW-1:0]] <= 1'b1;
      end
      v1 <= cmd.issue;
      v2 <= v1;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        pwm_phase <= (pwm_phase > PW'(PWM_TOP)) ? '0 : pwm_phase + PW'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sample) begin
      sample_reg <= sample;
    end
    if (cmd.start) begin
      tap_k  <= '0;
      rd_idx <= write_slot;
    end else if (cmd.issue) begin
      tap_k  <= tap_k + AW'(1);
      rd_idx <= (rd_idx == '0) ? AW'(TAP_COUNT - 1) : rd_idx - AW'(1);
    end
    s_ok    <= (CW'(rd_idx) < fill);
    c_ok    <= coef_vld[tap_k];
    tap_k_d <= tap_k;
    prod    <= coef_op * samp_op;
    if (cmd.start) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.load_out) begin
      led_pattern  <= (9'(pwm_phase) < 9'(level)) ? (led >> 1) : led;
      signal_value <= value;
      tilt_level   <= level;
    end
  end

  assign samp_op = s_ok ? signed'(ring_rdata) : '0;
  assign coef_op = c_ok ? signed'(coef_rdata) : ftli_default_coef(TAPNUM_W'(tap_k_d));

  // divide by 2^15, truncating toward zero
  assign acc_adj   = acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : '0);
  assign fir_value = VALUE_W'(acc_adj >>> FRAC_W);
  assign value     = cmd.filt ? fir_value : VALUE_W'(sample_reg);
  assign shifted   = value + LEVEL_OFFSET;
  assign sel       = shifted[8:6];
  assign level     = shifted[5:1];

  always_comb begin
    case (sel)
      3'd0:    led = 8'h08;
      3'd1:    led = 8'h04;
      3'd2:    led = 8'h02;
      3'd3:    led = 8'h01;
      3'd4:    led = 8'h80;
      3'd5:    led = 8'h40;
      3'd6:    led = 8'h20;
      3'd7:    led = 8'h10;
      default: led = 8'h00;
    endcase
  end

  assign stat.last_tap  = (tap_k == AW'(TAP_COUNT - 1));
  assign stat.pipe_busy = v1 | v2;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ===== sv/fir_tilt_led_indicator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_tilt_led_indicator
// Tilt indicator with optional FIR low-pass filter driving eight dimmed LEDs.
// ----------------------------------------------------------------------------
// Sequence: in raw mode an accepted sample goes straight to the finish state, which loads
//   the output register once it is free; in filtered mode the single multiply-accumulate
//   unit first walks the taps one per cycle and the product pipeline drains. A coefficient
//   write leaves the block ready; a new sample is taken only after the last result is loaded.
// Reset: clears control, the ring reads as zero until filled and coefficients read
//   the default low-pass set until written; no clearing pass.
module fir_tilt_led_indicator
  import ftli_pkg::*;
#(
  parameter int TAP_COUNT = 49,
  parameter int PWM_TOP   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,    // filter_enable
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // sample[12:0], tap_number[20:13], tap_weight[36:21]
  input  logic [0:0]           s_axis_tuser,   // cmd[0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // led_pattern[7:0], signal_value[39:8], tilt_level[44:40]
);

  ftli_cmd_t                  cmd;
  ftli_stat_t                 stat;
  logic [LED_W-1:0]           led_pattern;
  logic signed [VALUE_W-1:0]  signal_value;
  logic [LEVEL_W-1:0]         tilt_level;

  ftli_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (s_axis_tvalid),
    .req_cmd     (s_axis_tuser[0]),
    .req_ready   (s_axis_tready),
    .stat        (stat),
    .cmd         (cmd)
  );

  ftli_dp #(.TAP_COUNT(TAP_COUNT), .PWM_TOP(PWM_TOP)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (s_axis_tdata[12:0]),
    .tap_number   (s_axis_tdata[20:13]),
    .tap_weight   (s_axis_tdata[36:21]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .led_pattern  (led_pattern),
    .signal_value (signal_value),
    .tilt_level   (tilt_level)
  );

  assign m_axis_tdata = {3'b000, tilt_level, signal_value, led_pattern};

  a_coef_stays_ready: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_COEF) |=> s_axis_tready)
    else $error("coefficient write left the block busy");

  a_sample_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_SAMPLE) |=> !s_axis_tready)
    else $error("sample request did not start processing");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised without a sample in progress");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tilt indicator with optional FIR low-pass.
// Samples and coefficient writes go in over the input stream. An in-bench
// tilt predictor (ring, tap table, PWM counter) computes each result unless a
// directed row gives it; each result out is compared with the oldest pending.
// A directed table comes first, then random phases with the filter switched
// between modes, random gaps on both sides and idle pauses between phases.
// ----------------------------------------------------------------------------
module testbench;
  import ftli_pkg::*;

  localparam int TAP_COUNT   = 49;
  localparam int PWM_TOP     = 16;
  localparam int SETTLE_CYC  = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DIR_ROWS    = 23;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 235;

  localparam int LOWPASS_DEFAULT [TAP_COUNT] = '{
    152, 242, -79, -233, 107, 2, -307, 130, 143, -436,
    100, 375, -587, -35, 729, -737, -356, 1298, -863, -1106,
    2464, -947, -3944, 9435, 20869,
    9435, -3944, -947, 2464, -1106, -863, 1298, -356, -737, 729,
    -35, -587, 375, 100, -436, 143, 130, -307, 2, 107,
    -233, -79, 242, 152
  };

  typedef enum logic {ROW_SEND, ROW_CFG} row_kind_t;

  typedef struct {
    logic [LED_W-1:0]          led;
    logic signed [VALUE_W-1:0] value;
    logic [LEVEL_W-1:0]        level;
  } tilt_result_t;

  typedef struct {
    row_kind_t kind;
    logic      cfg;
    logic      cmd;
    int        smp;
    int        tap;
    int        wgt;
    bit        typed;
    int        e_led;
    int        e_value;
    int        e_level;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_wr_data = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // sample[12:0], tap_number[20:13], tap_weight[36:21]
  logic [0:0]           s_axis_tuser = '0;   // cmd[0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;  // led_pattern[7:0], signal_value[39:8], tilt_level[44:40]

  // predictor state
  logic signed [SAMPLE_W-1:0] hist_ring [TAP_COUNT];
  logic signed [COEF_W-1:0]   tap_coef [TAP_COUNT];
  int                         hist_slot;
  int                         pwm_count;
  logic                       filt_mode;

  tilt_result_t pending_results [$];
  int           err_cnt = 0;
  int           cycle_cnt = 0;
  int           rx_hold = 0;
  bit           tx_steady = 1'b0;
  bit           rx_steady = 1'b0;
  dir_row_t     dir_rows [DIR_ROWS];

  fir_tilt_led_indicator #(
    .TAP_COUNT (TAP_COUNT),
    .PWM_TOP   (PWM_TOP)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < TAP_COUNT; k++) begin
      hist_ring[k] = '0;
      tap_coef[k]  = COEF_W'(LOWPASS_DEFAULT[k]);
    end
    hist_slot = 0;
    pwm_count = 0;
    filt_mode = 1'b0;
  end

  task automatic predict_tilt(input logic cmd, input logic signed [SAMPLE_W-1:0] smp,
                              input logic [TAPNUM_W-1:0] tap,
                              input logic signed [COEF_W-1:0] wgt,
                              output tilt_result_t res, output bit produced);
    longint       acc;
    longint       shifted;
    int           newest;
    int           idx;
    logic [2:0]   sel;
    logic [LED_W-1:0] led;
    produced = 1'b0;
    res = '{default: '0};
    if (cmd == CMD_COEF) begin
      if (tap < TAP_COUNT) tap_coef[tap] = wgt;
      return;
    end
    newest = hist_slot;
    hist_ring[newest] = smp;
    hist_slot = (newest + 1 >= TAP_COUNT) ? 0 : newest + 1;
    if (filt_mode) begin
      acc = 0;
      for (int k = 0; k < TAP_COUNT; k++) begin
        idx = (newest >= k) ? newest - k : newest + TAP_COUNT - k;
        acc += longint'(tap_coef[k]) * longint'(hist_ring[idx]);
      end
      acc = acc / 32768;
    end else begin
      acc = longint'(hist_ring[newest]);
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    shifted = acc + longint'(LEVEL_OFFSET);
    sel = shifted[8:6];
    res.level = shifted[5:1];
    led = (sel < 3'd4) ? (8'd8 >> sel) : (8'd128 >> (sel - 3'd4));
    if (pwm_count < res.level) led = led >> 1;
    pwm_count = (pwm_count > PWM_TOP) ? 0 : pwm_count + 1;
    res.led = led;
    res.value = acc[VALUE_W-1:0];
    produced = 1'b1;
  endtask

  // hold the request until accepted, then log the expected tilt result
  task automatic send_item(input logic cmd, input logic signed [SAMPLE_W-1:0] smp,
                           input logic [TAPNUM_W-1:0] tap,
                           input logic signed [COEF_W-1:0] wgt,
                           input bit typed, input tilt_result_t typed_res);
    tilt_result_t res;
    bit           produced;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, wgt, tap, smp};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    predict_tilt(cmd, smp, tap, wgt, res, produced);
    if (produced) pending_results.push_back(typed ? typed_res : res);
  endtask

  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic idle_gap(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_filter(input logic en);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    filt_mode = en;
  endtask

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!rx_steady && $urandom_range(0, 99) < 20) begin
      m_axis_tready <= 1'b0;
      rx_hold <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 60);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tilt_result_t exp_res;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: tdata %h", m_axis_tdata);
        err_cnt = err_cnt + 1;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata[7:0] !== exp_res.led) begin
          $error("led_pattern: expected %0d, got %0d", exp_res.led, m_axis_tdata[7:0]);
          err_cnt = err_cnt + 1;
        end
        if (m_axis_tdata[39:8] !== exp_res.value) begin
          $error("signal_value: expected %0d, got %0d", exp_res.value,
                 $signed(m_axis_tdata[39:8]));
          err_cnt = err_cnt + 1;
        end
        if (m_axis_tdata[44:40] !== exp_res.level) begin
          $error("tilt_level: expected %0d, got %0d", exp_res.level, m_axis_tdata[44:40]);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  initial begin
    tilt_result_t              typed_res;
    logic                      cmd;
    logic signed [SAMPLE_W-1:0] smp;
    logic [TAPNUM_W-1:0]       tap;
    logic signed [COEF_W-1:0]  wgt;
    int                        r;

    dir_rows = '{
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 0,     0,   0,      1'b1, 8, 0,     16},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 4095,  0,   0,      1'b1, 8, 4095,  15},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, -4096, 0,   0,      1'b1, 8, -4096, 16},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 32,    0,   0,      1'b1, 8, 32,    0},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 96,    0,   0,      1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 160,   0,   0,      1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 224,   0,   0,      1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 288,   0,   0,      1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 352,   0,   0,      1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 416,   0,   0,      1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 490,   0,   0,      1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_COEF,   0,     0,   -32768, 1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_COEF,   0,     48,  32767,  1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_COEF,   0,     49,  1234,   1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_COEF,   0,     255, -1,     1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_COEF,   0,     24,  0,      1'b0, 0, 0,     0},
      '{ROW_CFG,  1'b1, CMD_SAMPLE, 0,     0,   0,      1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 4095,  0,   0,      1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, -4096, 0,   0,      1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 0,     0,   0,      1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, 4095,  0,   0,      1'b0, 0, 0,     0},
      '{ROW_CFG,  1'b0, CMD_SAMPLE, 0,     0,   0,      1'b0, 0, 0,     0},
      '{ROW_SEND, 1'b0, CMD_SAMPLE, -1,    0,   0,      1'b0, 0, 0,     0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_filter(dir_rows[i].cfg);
      end else begin
        typed_res.led   = LED_W'(dir_rows[i].e_led);
        typed_res.value = VALUE_W'(dir_rows[i].e_value);
        typed_res.level = LEVEL_W'(dir_rows[i].e_level);
        send_item(dir_rows[i].cmd, SAMPLE_W'(dir_rows[i].smp), TAPNUM_W'(dir_rows[i].tap),
                  COEF_W'(dir_rows[i].wgt), dir_rows[i].typed, typed_res);
        idle_gap(pick_gap());
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_filter((ph % 2) == 0);
      tx_steady = (ph == 2);
      rx_steady = (ph == 2) || (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        cmd = (r < 12) ? CMD_COEF : CMD_SAMPLE;
        tap = ($urandom_range(0, 99) < 85) ? TAPNUM_W'($urandom_range(0, TAP_COUNT - 1))
                                            : TAPNUM_W'($urandom_range(0, 255));
        case ($urandom_range(0, 19))
          0:       wgt = 16'sh8000;
          1:       wgt = 16'sh7fff;
          default: wgt = COEF_W'($urandom);
        endcase
        case ($urandom_range(0, 39))
          0:       smp = -13'sd4096;
          1:       smp = 13'sd4095;
          2:       smp = '0;
          3:       smp = '1;
          default: smp = SAMPLE_W'($urandom);
        endcase
        send_item(cmd, smp, tap, wgt, 1'b0, typed_res);
        if ($urandom_range(0, 149) == 0) drain_results();
        else idle_gap(pick_gap());
      end
    end

    drain_results();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ftli_pkg.sv
sv/ftli_ram.sv
sv/ftli_ctrl.sv
sv/ftli_dp.sv
sv/fir_tilt_led_indicator.sv
bench/testbench.sv
